// ----- src/ltc_pkg.sv -----
// ----------------------------------------------------------------------------
// ltc_pkg : shared types and constants for the loop trip-count table
// Table geometry, counter record, controller command/status bundles.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 32;
  localparam int ADDR_W        = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int OUT_IDX_W     = 6;
  localparam int OUT_CNT_W     = 32;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef struct packed {
    cnt_t seen;
    cnt_t exits;
    cnt_t changes;
    cnt_t running;
    cnt_t prev;
  } cnt_rec_t;

  localparam int REC_W = $bits(cnt_rec_t);

  typedef enum logic [1:0] {
    MODE_HIT,
    MODE_NEW,
    MODE_FULL
  } ltc_mode_t;

  typedef struct packed {
    logic      load_in;
    logic      idx_clr;
    logic      idx_inc;
    logic      tag_rd;
    logic      alloc;
    logic      cnt_rd;
    logic      commit;
    ltc_mode_t mode;
  } ltc_cmd_t;

  typedef struct packed {
    logic used_zero;
    logic full;
    logic tag_hit;
    logic idx_last;
    logic out_free;
  } ltc_stat_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

endpackage

// ----- src/ltc_ram.sv -----
// ----------------------------------------------------------------------------
// ltc_ram : generic single-write, single-read RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ltc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ltc_ctrl : sequencer for the loop trip-count table
// Walks the tag store one entry at a time, then updates, allocates or reports a full table.
// ----------------------------------------------------------------------------
module ltc_ctrl
  import ltc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ltc_stat_t stat,
  output ltc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAG_RD,
    S_TAG_CMP,
    S_MISS,
    S_CNT_RD,
    S_UPDATE
  } state_t;

  state_t    state, state_next;
  ltc_mode_t mode, mode_next;

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd        = '0;
    cmd.mode   = mode;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = stat.used_zero ? S_MISS : S_TAG_RD;
        end
      end
      S_TAG_RD: begin
        cmd.tag_rd = 1'b1;
        state_next = S_TAG_CMP;
      end
      S_TAG_CMP: begin
        if (stat.tag_hit) begin
          state_next = S_CNT_RD;
        end else if (stat.idx_last) begin
          state_next = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_TAG_RD;
        end
      end
      S_MISS: begin
        if (stat.full) begin
          mode_next = MODE_FULL;
        end else begin
          cmd.alloc = 1'b1;
          mode_next = MODE_NEW;
        end
        state_next = S_UPDATE;
      end
      S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        mode_next  = MODE_HIT;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_HIT;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

endmodule

// ----- src/ltc_dp.sv -----
// ----------------------------------------------------------------------------
// ltc_dp : datapath for the loop trip-count table
// Tag and counter stores, entry pointer, fill count, counter update and
// output register.
// ----------------------------------------------------------------------------
module ltc_dp
  import ltc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ltc_cmd_t             cmd,
  output ltc_stat_t            stat,
  input  logic [ADDR_W-1:0]    branch_target,
  input  logic                 branch_taken,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] entry_index,
  output logic                 table_full,
  output logic [OUT_CNT_W-1:0] times_seen,
  output logic [OUT_CNT_W-1:0] times_invoked,
  output logic [OUT_CNT_W-1:0] trip_changes,
  output logic [OUT_CNT_W-1:0] current_iterations,
  output logic [OUT_CNT_W-1:0] last_trip_count
);

  logic [ADDR_W-1:0] addr_q;
  logic              taken_q;
  logic [IDX_W-1:0]  idx;
  logic [USED_W-1:0] used;
  logic [ADDR_W-1:0] tag_rdata;
  cnt_rec_t          cnt_rdata;
  cnt_rec_t          base, upd;
  logic              cnt_wr;

  ltc_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.alloc),
    .wr_addr (used[IDX_W-1:0]),
    .wr_data (addr_q),
    .rd_en   (cmd.tag_rd),
    .rd_addr (idx),
    .rd_data (tag_rdata)
  );

  assign cnt_wr = cmd.commit && (cmd.mode != MODE_FULL);

  ltc_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr),
    .wr_addr (idx),
    .wr_data (upd),
    .rd_en   (cmd.cnt_rd),
    .rd_addr (idx),
    .rd_data (cnt_rdata)
  );

  always_comb begin
    stat.used_zero = (used == '0);
    stat.full      = (used == USED_W'(TABLE_ENTRIES));
    stat.tag_hit   = (tag_rdata == addr_q);
    stat.idx_last  = ((USED_W'(idx) + USED_W'(1)) == used);
    stat.out_free  = !out_valid || out_ready;
  end

  // fresh entries start from zero counters
  always_comb begin
    base        = (cmd.mode == MODE_NEW) ? '0 : cnt_rdata;
    upd         = base;
    upd.seen    = sat_inc(base.seen);
    if (taken_q) begin
      upd.running = sat_inc(base.running);
    end else begin
      upd.exits   = sat_inc(base.exits);
      if (base.running != base.prev) begin
        upd.changes = sat_inc(base.changes);
      end
      upd.prev    = base.running;
      upd.running = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_q  <= branch_target;
      taken_q <= branch_taken;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end else if (cmd.alloc) begin
      idx <= used[IDX_W-1:0];
    end
    if (cmd.commit) begin
      if (cmd.mode == MODE_FULL) begin
        entry_index        <= '0;
        table_full         <= 1'b1;
        times_seen         <= '0;
        times_invoked      <= '0;
        trip_changes       <= '0;
        current_iterations <= '0;
        last_trip_count    <= '0;
      end else begin
        entry_index        <= OUT_IDX_W'(idx);
        table_full         <= 1'b0;
        times_seen         <= OUT_CNT_W'(upd.seen);
        times_invoked      <= OUT_CNT_W'(upd.exits);
        trip_changes       <= OUT_CNT_W'(upd.changes);
        current_iterations <= OUT_CNT_W'(upd.running);
        last_trip_count    <= OUT_CNT_W'(upd.prev);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        used <= used + USED_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> !stat.full)
    else $error("allocation into a full table");

  a_scan_in_use: assert property (@(posedge clk) disable iff (rst)
    cmd.tag_rd |-> (USED_W'(idx) < used))
    else $error("tag read beyond allocated entries");

  a_full_no_alloc: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cmd.mode == MODE_FULL) |-> (stat.full && !cmd.alloc))
    else $error("full result while table has room");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed word not presented");

endmodule

// ----- src/loop_trip_count_table.sv -----
// ----------------------------------------------------------------------------
// loop_trip_count_table : per-loop iteration and trip-count profiler
// Fully associative table of loops keyed by branch target, with saturating
// sighting, exit, trip-change and running counters and a last-trip count.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   branch_target, branch_taken
//   output   out_valid / out_ready entry_index, table_full, times_seen,
//                                  times_invoked, trip_changes,
//                                  current_iterations, last_trip_count
//
// One word at a time. The tag store is searched one entry at a time
// (read, compare) through its single read port; a hit then reads the counters,
// a miss (or an empty table, which skips the search) allocates or reports full.
// A new word is accepted as soon as the previous result is in the output
// register, even while that result is stalled; the sequencer then holds
// before its commit. Reset empties the table at once (fill count only).
// ----------------------------------------------------------------------------
module loop_trip_count_table
  import ltc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_W-1:0]    branch_target,
  input  logic                 branch_taken,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_IDX_W-1:0] entry_index,
  output logic                 table_full,
  output logic [OUT_CNT_W-1:0] times_seen,
  output logic [OUT_CNT_W-1:0] times_invoked,
  output logic [OUT_CNT_W-1:0] trip_changes,
  output logic [OUT_CNT_W-1:0] current_iterations,
  output logic [OUT_CNT_W-1:0] last_trip_count
);

  ltc_cmd_t  cmd;
  ltc_stat_t stat;

  ltc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ltc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .branch_target      (branch_target),
    .branch_taken       (branch_taken),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .entry_index        (entry_index),
    .table_full         (table_full),
    .times_seen         (times_seen),
    .times_invoked      (times_invoked),
    .trip_changes       (trip_changes),
    .current_iterations (current_iterations),
    .last_trip_count    (last_trip_count)
  );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb : self-checking bench for the loop trip-count table
// Drives branch events through the valid/ready input, predicts every result
// word with its own copy of the loop table and compares each word field by
// field as it leaves the block. Random idling on both sides, one long output
// hold-off that backs the block up, and a table filled to overflow.
// ----------------------------------------------------------------------------
module tb;
  import ltc_pkg::*;

  localparam int TOTAL_WORDS = 450;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic                 full;
    logic [OUT_CNT_W-1:0] seen;
    logic [OUT_CNT_W-1:0] invoked;
    logic [OUT_CNT_W-1:0] changes;
    logic [OUT_CNT_W-1:0] running;
    logic [OUT_CNT_W-1:0] last;
  } trip_report_t;

  // Shadow of the loop table; one expected report per accepted event.
  class loop_profile_tracker;
    logic [ADDR_W-1:0] tags [TABLE_ENTRIES];
    cnt_t              seen [TABLE_ENTRIES];
    cnt_t              exits [TABLE_ENTRIES];
    cnt_t              changes [TABLE_ENTRIES];
    cnt_t              running [TABLE_ENTRIES];
    cnt_t              prev [TABLE_ENTRIES];
    int                used;
    int                errors;
    trip_report_t      expected_reports [$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function cnt_t bump(input cnt_t v);
      return (&v) ? v : cnt_t'(v + 1'b1);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_word(input logic [ADDR_W-1:0] addr, input logic taken);
      trip_report_t r;
      int slot;
      slot = -1;
      r = '0;
      for (int i = 0; i < used; i++) begin
        if (tags[i] == addr) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        // unknown loop with no room left: report and change nothing
        if (used == TABLE_ENTRIES) begin
          r.full = 1'b1;
          expected_reports.push_back(r);
          return;
        end
        slot = used;
        used++;
        tags[slot]    = addr;
        seen[slot]    = '0;
        exits[slot]   = '0;
        changes[slot] = '0;
        running[slot] = '0;
        prev[slot]    = '0;
      end
      seen[slot] = bump(seen[slot]);
      if (taken) begin
        running[slot] = bump(running[slot]);
      end else begin
        exits[slot] = bump(exits[slot]);
        if (running[slot] != prev[slot]) changes[slot] = bump(changes[slot]);
        prev[slot]    = running[slot];
        running[slot] = '0;
      end
      r.idx     = OUT_IDX_W'(slot);
      r.seen    = OUT_CNT_W'(seen[slot]);
      r.invoked = OUT_CNT_W'(exits[slot]);
      r.changes = OUT_CNT_W'(changes[slot]);
      r.running = OUT_CNT_W'(running[slot]);
      r.last    = OUT_CNT_W'(prev[slot]);
      expected_reports.push_back(r);
    endfunction

    function void match(input string field, input logic [63:0] want,
                        input logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(input trip_report_t got);
      trip_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result word with nothing outstanding: entry_index 'h%0h", got.idx);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      match("entry_index", 64'(want.idx), 64'(got.idx));
      match("table_full", 64'(want.full), 64'(got.full));
      match("times_seen", 64'(want.seen), 64'(got.seen));
      match("times_invoked", 64'(want.invoked), 64'(got.invoked));
      match("trip_changes", 64'(want.changes), 64'(got.changes));
      match("current_iterations", 64'(want.running), 64'(got.running));
      match("last_trip_count", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADDR_W-1:0]    branch_target = '0;
  logic                 branch_taken = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_IDX_W-1:0] entry_index;
  logic                 table_full;
  logic [OUT_CNT_W-1:0] times_seen;
  logic [OUT_CNT_W-1:0] times_invoked;
  logic [OUT_CNT_W-1:0] trip_changes;
  logic [OUT_CNT_W-1:0] current_iterations;
  logic [OUT_CNT_W-1:0] last_trip_count;

  loop_profile_tracker profile = new();
  logic [ADDR_W-1:0]   loops [$];
  int                  habits [$];
  int                  words_sent = 0;
  int unsigned         cycle_count = 0;
  bit                  calm = 1'b0;
  bit                  hold_off_req = 1'b0;

  loop_trip_count_table DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .branch_target      (branch_target),
    .branch_taken       (branch_taken),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .entry_index        (entry_index),
    .table_full         (table_full),
    .times_seen         (times_seen),
    .times_invoked      (times_invoked),
    .trip_changes       (trip_changes),
    .current_iterations (current_iterations),
    .last_trip_count    (last_trip_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      profile.check_word(trip_report_t'({entry_index, table_full, times_seen,
                                         times_invoked, trip_changes,
                                         current_iterations, last_trip_count}));
  end

  // Output side: short random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic bit is_known(input logic [ADDR_W-1:0] addr);
    foreach (loops[i]) if (loops[i] == addr) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [ADDR_W-1:0] fresh_addr();
    logic [ADDR_W-1:0] addr;
    do addr = {$urandom, $urandom}; while (is_known(addr));
    return addr;
  endfunction

  // Track a loop on the stimulus side; returns its position, or -1 when the
  // table has no room for it.
  function automatic int track_loop(input logic [ADDR_W-1:0] addr);
    foreach (loops[i]) if (loops[i] == addr) return i;
    if (loops.size() == TABLE_ENTRIES) return -1;
    loops.push_back(addr);
    habits.push_back($urandom_range(0, 6));
    return loops.size() - 1;
  endfunction

  task automatic send_word(input logic [ADDR_W-1:0] addr, input logic taken);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    branch_target <= addr;
    branch_taken  <= taken;
    do @(posedge clk); while (!in_ready);
    profile.note_word(addr, taken);
    // words dropped by a full table do not count
    if (is_known(addr)) words_sent++;
  endtask

  task automatic run_trip(input logic [ADDR_W-1:0] addr, input int trip,
                          input bit close);
    repeat (trip) send_word(addr, 1'b1);
    if (close) send_word(addr, 1'b0);
  endtask

  task automatic wait_drained();
    while (profile.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] addr;
    int pos;
    int trip;
    bit hold_done;
    hold_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: address extremes, exit on an empty trip, repeated and
    // changed trip counts, interleaved loops.
    void'(track_loop('0));
    void'(track_loop('1));
    void'(track_loop(64'h8000_0000_0000_0000));
    void'(track_loop(64'h5555_5555_5555_5555));
    void'(track_loop(64'hAAAA_AAAA_AAAA_AAAA));
    send_word('0, 1'b0);
    run_trip('0, 2, 1'b1);
    run_trip('1, 2, 1'b0);
    send_word('1, 1'b0);
    run_trip('0, 2, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b1);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Random: mostly whole trips with habitual counts, some noise and
    // unfinished trips; the table is topped up and then overflowed.
    while (words_sent < TOTAL_WORDS) begin
      calm = (words_sent >= TOTAL_WORDS - 60);
      if (!hold_done && words_sent >= 150) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (words_sent >= 220) begin
        while (loops.size() < TABLE_ENTRIES) begin
          addr = fresh_addr();
          void'(track_loop(addr));
          send_word(addr, 1'($urandom_range(0, 1)));
        end
      end
      if (loops.size() == 0 ||
          $urandom_range(0, 99) < (loops.size() == TABLE_ENTRIES ? 8 : 30)) begin
        addr = fresh_addr();
        pos  = track_loop(addr);
        if (pos < 0) begin
          send_word(addr, 1'($urandom_range(0, 1)));
          continue;
        end
      end else begin
        pos  = $urandom_range(0, loops.size() - 1);
        addr = loops[pos];
      end
      case ($urandom_range(0, 9))
        0: send_word(addr, 1'($urandom_range(0, 1)));
        1: run_trip(addr, $urandom_range(0, 8), 1'b0);
        default: begin
          trip = ($urandom_range(0, 2) != 0) ? habits[pos] : $urandom_range(0, 8);
          if ($urandom_range(0, 7) == 0) habits[pos] = trip;
          run_trip(addr, trip, 1'b1);
        end
      endcase
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (profile.errors == 0 && profile.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- loop_trip_count_table.f -----
src/ltc_pkg.sv
src/ltc_ram.sv
src/ltc_ctrl.sv
src/ltc_dp.sv
src/loop_trip_count_table.sv
tb/tb.sv
